### design/hrc_pkg.sv
// hrc_pkg: shared types and constants for the heading rate controller.
// No dependencies; used by heading_rate_controller, hrc_err and hrc_slew.

package hrc_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int RATE_BITS_DEF  = 24;

    localparam int MAX_RATE_W  = 23;
    localparam int MAX_ACCEL_W = 24;
    localparam int RATE_STEP_W = 23;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_RATE      = 2'd0,
        REG_MAX_ACCEL     = 2'd1,
        REG_MAX_RATE_STEP = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [MAX_RATE_W-1:0]  max_rate;
        logic [MAX_ACCEL_W-1:0] max_accel;
        logic [RATE_STEP_W-1:0] max_rate_step;
    } t_cfg;

endpackage

### design/heading_rate_controller.sv
// heading_rate_controller: heading error -> square-root braking rate -> slew limit.
// Pipeline: 2 error/multiply stages, one root bit per stage, 3 limit stages.
// Throughput: one request per cycle while the output is not stalled; each stage holds
// its own valid, so bubbles close up.
// Reset (synchronous, active low) empties the pipeline and clears all config registers.
// Depends on hrc_pkg, hrc_err, hrc_sqrt, hrc_slew.

module heading_rate_controller #(
    parameter int ANGLE_BITS = hrc_pkg::ANGLE_BITS_DEF,
    parameter int RATE_BITS  = hrc_pkg::RATE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [hrc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [hrc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // input requests
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [ANGLE_BITS-1:0]             i_target_heading,
    input  logic [ANGLE_BITS-1:0]             i_measured_heading,
    input  logic signed [RATE_BITS-1:0]       i_measured_rate,
    // result requests
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [RATE_BITS-1:0]       o_commanded_rate
);

    // radicand = (max_accel * |error|) >> 1, root has half its bits, rounded up
    localparam int PW     = hrc_pkg::MAX_ACCEL_W + ANGLE_BITS - 1;
    localparam int RB     = (PW + 1) / 2;
    localparam int SIDE_W = RATE_BITS + 1;

    hrc_pkg::t_cfg r_cfg;

    logic                        w_e_valid;
    logic                        w_e_ready;
    logic [PW-1:0]               w_e_rad;
    logic                        w_e_neg;
    logic signed [RATE_BITS-1:0] w_e_rate;
    logic                        w_q_valid;
    logic                        w_q_ready;
    logic [RB-1:0]               w_q_root;
    logic [SIDE_W-1:0]           w_q_side;

    // Config registers: the user must write them only while the pipeline is idle, which the block
    // does not enforce, so every stage may read them directly. Writes to the unused index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hrc_pkg::REG_MAX_RATE: begin
                    r_cfg.max_rate <= i_cfg_wdata[hrc_pkg::MAX_RATE_W-1:0];
                end
                hrc_pkg::REG_MAX_ACCEL: begin
                    r_cfg.max_accel <= i_cfg_wdata[hrc_pkg::MAX_ACCEL_W-1:0];
                end
                hrc_pkg::REG_MAX_RATE_STEP: begin
                    r_cfg.max_rate_step <= i_cfg_wdata[hrc_pkg::RATE_STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // wrap the error to a half turn, form the radicand (one 24 x ANGLE_BITS multiply)
    hrc_err #(
        .ANGLE_BITS (ANGLE_BITS),
        .RATE_BITS  (RATE_BITS)
    ) u_err (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_valid            (i_in_valid),
        .o_ready            (o_in_ready),
        .i_target_heading   (i_target_heading),
        .i_measured_heading (i_measured_heading),
        .i_measured_rate    (i_measured_rate),
        .o_valid            (w_e_valid),
        .i_ready            (w_e_ready),
        .o_rad              (w_e_rad),
        .o_neg              (w_e_neg),
        .o_rate             (w_e_rate)
    );

    // floored root, error sign and measured rate ride along as sideband
    hrc_sqrt #(
        .IN_W   (PW),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_e_valid),
        .o_ready (w_e_ready),
        .i_rad   (w_e_rad),
        .i_side  ({w_e_neg, w_e_rate}),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_root  (w_q_root),
        .o_side  (w_q_side)
    );

    // cap, sign, slew limit against the measured rate, saturate
    hrc_slew #(
        .RATE_BITS (RATE_BITS),
        .ROOT_W    (RB)
    ) u_slew (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_root  (w_q_root),
        .i_neg   (w_q_side[SIDE_W-1]),
        .i_rate  (w_q_side[RATE_BITS-1:0]),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_rate  (o_commanded_rate)
    );

    // input can only back up when a finished result is waiting at the output
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    // the first cycle out of reset shows no result
    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // a write to the unused register index changes nothing
    a_unused_idx_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && i_cfg_idx != hrc_pkg::REG_MAX_RATE
            && i_cfg_idx != hrc_pkg::REG_MAX_ACCEL
            && i_cfg_idx != hrc_pkg::REG_MAX_RATE_STEP |=> $stable(r_cfg))
        else $error("config changed by write to unused index");

endmodule

### design/hrc_err.sv
// hrc_err: heading error wrap and braking-profile radicand, two stages.
// Depends on hrc_pkg (t_cfg, MAX_ACCEL_W).

module hrc_err #(
    parameter int ANGLE_BITS = hrc_pkg::ANGLE_BITS_DEF,
    parameter int RATE_BITS  = hrc_pkg::RATE_BITS_DEF,
    localparam int PW = hrc_pkg::MAX_ACCEL_W + ANGLE_BITS - 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hrc_pkg::t_cfg               i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ANGLE_BITS-1:0]       i_target_heading,
    input  logic [ANGLE_BITS-1:0]       i_measured_heading,
    input  logic signed [RATE_BITS-1:0] i_measured_rate,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [PW-1:0]               o_rad,
    output logic                        o_neg,
    output logic signed [RATE_BITS-1:0] o_rate
);

    logic [ANGLE_BITS-1:0] w_d;
    logic [ANGLE_BITS-1:0] w_mag;
    logic                  w_neg;
    logic [PW:0]           w_prod;
    logic                  w_adv1;
    logic                  w_adv2;

    logic                        r_s1_vld;
    logic [ANGLE_BITS-1:0]       r_s1_mag;
    logic                        r_s1_neg;
    logic signed [RATE_BITS-1:0] r_s1_rate;
    logic                        r_s2_vld;
    logic [PW-1:0]               r_s2_rad;
    logic                        r_s2_neg;
    logic signed [RATE_BITS-1:0] r_s2_rate;

    // exactly half a turn has the sign bit set, so it counts as negative
    assign w_d   = i_target_heading - i_measured_heading;
    assign w_neg = w_d[ANGLE_BITS-1];
    assign w_mag = w_neg ? (~w_d + {{(ANGLE_BITS-1){1'b0}}, 1'b1}) : w_d;

    assign w_prod = {{ANGLE_BITS{1'b0}}, i_cfg.max_accel}
                  * {{hrc_pkg::MAX_ACCEL_W{1'b0}}, r_s1_mag};

    assign w_adv2  = !r_s2_vld || i_ready;
    assign w_adv1  = !r_s1_vld || w_adv2;
    assign o_ready = w_adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (w_adv1) r_s1_vld <= i_valid;
            if (w_adv2) r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_s1_mag  <= w_mag;
            r_s1_neg  <= w_neg;
            r_s1_rate <= i_measured_rate;
        end
        if (w_adv2) begin
            r_s2_rad  <= w_prod[PW:1];
            r_s2_neg  <= r_s1_neg;
            r_s2_rate <= r_s1_rate;
        end
    end

    assign o_valid = r_s2_vld;
    assign o_rad   = r_s2_rad;
    assign o_neg   = r_s2_neg;
    assign o_rate  = r_s2_rate;

endmodule

### design/hrc_sqrt.sv
// hrc_sqrt: pipelined floored integer square root, one root bit per stage.
// No package dependencies; sideband bits travel with each request.

module hrc_sqrt #(
    parameter int IN_W   = 39,
    parameter int SIDE_W = 25,
    localparam int RB    = (IN_W + 1) / 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [IN_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [RB-1:0]     o_root,
    output logic [SIDE_W-1:0] o_side
);

    localparam int RAD_W = 2 * RB;
    localparam int REM_W = RB + 2;
    localparam int TW    = REM_W + 2;

    logic              r_vld  [1:RB];
    logic [RAD_W-1:0]  r_rad  [1:RB];
    logic [REM_W-1:0]  r_rem  [1:RB];
    logic [RB-1:0]     r_root [1:RB];
    logic [SIDE_W-1:0] r_side [1:RB];
    logic [RB+1:1]     w_adv;

    assign w_adv[RB+1] = i_ready;

    genvar k;
    for (k = 1; k <= RB; k++) begin : g_stage
        logic              p_vld;
        logic [RAD_W-1:0]  p_rad;
        logic [REM_W-1:0]  p_rem;
        logic [RB-1:0]     p_root;
        logic [SIDE_W-1:0] p_side;
        logic [TW-1:0]     w_sh;
        logic [TW-1:0]     w_sub;
        logic [TW-1:0]     w_dif;
        logic              w_ge;

        if (k == 1) begin : g_first
            assign p_vld  = i_valid;
            assign p_rad  = RAD_W'(i_rad);
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_side = r_side[k-1];
        end

        // trial subtract of (4*root + 1) from the shifted partial remainder
        assign w_sh  = {p_rem, p_rad[RAD_W-1 -: 2]};
        assign w_sub = {2'b00, p_root, 2'b01};
        assign w_dif = w_sh - w_sub;
        assign w_ge  = (w_sh >= w_sub);

        assign w_adv[k] = !r_vld[k] || w_adv[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_adv[k]) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[k]) begin
                r_rad[k]  <= p_rad << 2;
                r_rem[k]  <= w_ge ? w_dif[REM_W-1:0] : w_sh[REM_W-1:0];
                r_root[k] <= {p_root[RB-2:0], w_ge};
                r_side[k] <= p_side;
            end
        end
    end

    assign o_ready = w_adv[1];
    assign o_valid = r_vld[RB];
    assign o_root  = r_root[RB];
    assign o_side  = r_side[RB];

endmodule

### design/hrc_slew.sv
// hrc_slew: rate cap, sign, slew limit and output saturation, three stages.
// Depends on hrc_pkg (t_cfg, register widths).

module hrc_slew #(
    parameter int RATE_BITS = hrc_pkg::RATE_BITS_DEF,
    parameter int ROOT_W    = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hrc_pkg::t_cfg               i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ROOT_W-1:0]           i_root,
    input  logic                        i_neg,
    input  logic signed [RATE_BITS-1:0] i_rate,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [RATE_BITS-1:0] o_rate
);

    localparam int MR_W = hrc_pkg::MAX_RATE_W;
    localparam int CW   = (ROOT_W > MR_W) ? ROOT_W : MR_W;
    localparam int EW   = ((RATE_BITS > MR_W + 1) ? RATE_BITS : MR_W + 1) + 2;
    localparam logic signed [EW-1:0] SAT_HI =
        {{(EW-RATE_BITS+1){1'b0}}, {(RATE_BITS-1){1'b1}}};
    localparam logic signed [EW-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [1:0] {
        SEL_PROF = 2'd0,
        SEL_HI   = 2'd1,
        SEL_LO   = 2'd2
    } t_sel;

    logic [CW-1:0]          w_root_x;
    logic [CW-1:0]          w_cap_x;
    logic signed [EW-1:0]   w_mag;
    logic signed [EW-1:0]   w_v;
    logic signed [EW-1:0]   w_diff;
    logic signed [EW-1:0]   w_step;
    logic signed [EW-1:0]   w_pick;
    logic [RATE_BITS-1:0]   w_sat;
    logic                   w_adv_a;
    logic                   w_adv_b;
    logic                   w_adv_c;

    logic                   r_a_vld;
    logic signed [EW-1:0]   r_a_v;
    logic signed [EW-1:0]   r_a_rate;
    logic                   r_b_vld;
    t_sel                   r_b_sel;
    logic signed [EW-1:0]   r_b_v;
    logic signed [EW-1:0]   r_b_hi;
    logic signed [EW-1:0]   r_b_lo;
    logic                   r_c_vld;
    logic [RATE_BITS-1:0]   r_c_rate;

    // stage A: cap the profile at max_rate and give it the error's sign
    assign w_root_x = CW'(i_root);
    assign w_cap_x  = (w_root_x > CW'(i_cfg.max_rate)) ? CW'(i_cfg.max_rate) : w_root_x;
    assign w_mag    = EW'(w_cap_x[MR_W-1:0]);
    assign w_v      = i_neg ? -w_mag : w_mag;

    // stage B: compare the change against the step bound
    assign w_step = EW'(i_cfg.max_rate_step);
    assign w_diff = r_a_v - r_a_rate;

    // stage C: pick and saturate
    always_comb begin
        case (r_b_sel)
            SEL_HI:  w_pick = r_b_hi;
            SEL_LO:  w_pick = r_b_lo;
            default: w_pick = r_b_v;
        endcase
        if (w_pick > SAT_HI) begin
            w_sat = SAT_HI[RATE_BITS-1:0];
        end else if (w_pick < SAT_LO) begin
            w_sat = SAT_LO[RATE_BITS-1:0];
        end else begin
            w_sat = w_pick[RATE_BITS-1:0];
        end
    end

    assign w_adv_c = !r_c_vld || i_ready;
    assign w_adv_b = !r_b_vld || w_adv_c;
    assign w_adv_a = !r_a_vld || w_adv_b;
    assign o_ready = w_adv_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            if (w_adv_a) r_a_vld <= i_valid;
            if (w_adv_b) r_b_vld <= r_a_vld;
            if (w_adv_c) r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_a) begin
            r_a_v    <= w_v;
            r_a_rate <= EW'(i_rate);
        end
        if (w_adv_b) begin
            if (w_diff > w_step) begin
                r_b_sel <= SEL_HI;
            end else if (w_diff < -w_step) begin
                r_b_sel <= SEL_LO;
            end else begin
                r_b_sel <= SEL_PROF;
            end
            r_b_v  <= r_a_v;
            r_b_hi <= r_a_rate + w_step;
            r_b_lo <= r_a_rate - w_step;
        end
        if (w_adv_c) begin
            r_c_rate <= w_sat;
        end
    end

    assign o_valid = r_c_vld;
    assign o_rate  = r_c_rate;

endmodule

### tb/heading_rate_controller_tb.sv
`timescale 1ns / 1ps
// heading_rate_controller_tb: self-checking bench for the heading rate controller.
// Sends heading/rate requests under random gaps and back-pressure and checks every
// commanded rate against an in-bench predictor. Depends on hrc_pkg and the design.

module heading_rate_controller_tb;

    typedef longint unsigned t_u64;

    localparam int ANGLE_W = hrc_pkg::ANGLE_BITS_DEF;
    localparam int RATE_W  = hrc_pkg::RATE_BITS_DEF;
    // pipeline depth in stages, used for settle time only
    localparam int PIPE_LATENCY = (hrc_pkg::MAX_ACCEL_W + ANGLE_W) / 2 + 5;
    localparam int RUN_LIMIT_NS = 1_000_000;

    // index past the end of the register file; the design must drop the write
    localparam logic [hrc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [hrc_pkg::CFG_DATA_W-1:0] CFG_ALL_ONES = '1;
    localparam logic [ANGLE_W-1:0]       HALF_TURN    = {1'b1, {(ANGLE_W-1){1'b0}}};
    localparam logic [ANGLE_W-1:0]       ANGLE_MAX_V  = '1;
    localparam logic signed [RATE_W-1:0] RATE_MAX_V   = {1'b0, {(RATE_W-1){1'b1}}};
    localparam logic signed [RATE_W-1:0] RATE_MIN_V   = {1'b1, {(RATE_W-1){1'b0}}};
    localparam longint RATE_HI = (longint'(1) <<< (RATE_W - 1)) - 1;
    localparam longint RATE_LO = -RATE_HI - 1;

    // ---------------------------------------------------------------
    // DUT connections, all inputs known from time zero
    // ---------------------------------------------------------------
    logic                             i_clk     = 1'b0;
    logic                             i_rst_n   = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [hrc_pkg::CFG_IDX_W-1:0]    cfg_idx   = '0;
    logic [hrc_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    logic [ANGLE_W-1:0]               target_hdg = '0;
    logic [ANGLE_W-1:0]               meas_hdg   = '0;
    logic signed [RATE_W-1:0]         meas_rate  = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic signed [RATE_W-1:0]         cmd_rate;

    heading_rate_controller dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_idx          (cfg_idx),
        .i_cfg_wdata        (cfg_wdata),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_target_heading   (target_hdg),
        .i_measured_heading (meas_hdg),
        .i_measured_rate    (meas_rate),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_commanded_rate   (cmd_rate)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Bench copy of the limit registers (reset value is zero)
    // ---------------------------------------------------------------
    logic [hrc_pkg::MAX_RATE_W-1:0]  lim_max_rate  = '0;
    logic [hrc_pkg::MAX_ACCEL_W-1:0] lim_max_accel = '0;
    logic [hrc_pkg::RATE_STEP_W-1:0] lim_rate_step = '0;

    // commanded rates predicted for accepted requests, oldest first
    logic signed [RATE_W-1:0] expected_cmd_q[$];
    logic signed [RATE_W-1:0] want_cmd;
    int n_fail = 0;

    // idle odds in percent per decision point; zero means a steady stream
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int stall_left = 0;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic t_u64 floor_sqrt(input t_u64 v);
        t_u64 root;
        t_u64 cand;
        root = 0;
        // product is below 2^39, so a 32-bit root search is plenty
        for (int b = 31; b >= 0; b--) begin
            cand = root | (t_u64'(1) << b);
            if (cand * cand <= v) root = cand;
        end
        return root;
    endfunction

    function automatic logic signed [RATE_W-1:0] predict_cmd_rate(
        input logic [ANGLE_W-1:0]       tgt,
        input logic [ANGLE_W-1:0]       meas,
        input logic signed [RATE_W-1:0] rate
    );
        logic [ANGLE_W-1:0] err;
        t_u64   mag;
        t_u64   root;
        longint cmd;
        longint rate_l;
        longint lim;
        err = tgt - meas;
        // top bit set means the negative half; exactly half a turn lands here too
        if (err[ANGLE_W-1]) mag = (t_u64'(1) << ANGLE_W) - t_u64'(err);
        else                mag = t_u64'(err);
        root = floor_sqrt((t_u64'(lim_max_accel) * mag) >> 1);
        if (root > t_u64'(lim_max_rate)) root = t_u64'(lim_max_rate);
        cmd    = err[ANGLE_W-1] ? -longint'(root) : longint'(root);
        rate_l = rate;
        lim    = longint'(lim_rate_step);
        // slew limit around the measured rate
        if (cmd - rate_l > lim)       cmd = rate_l + lim;
        else if (cmd - rate_l < -lim) cmd = rate_l - lim;
        if (cmd > RATE_HI) cmd = RATE_HI;
        if (cmd < RATE_LO) cmd = RATE_LO;
        return cmd[RATE_W-1:0];
    endfunction

    // ---------------------------------------------------------------
    // Result side: random back-pressure bursts of stalled cycles
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (sink_stall_pct != 0 && $urandom_range(99, 0) < sink_stall_pct) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(17, 0);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Checker: every accepted result request against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_cmd_q.size() == 0) begin
                $display("%0t: unexpected commanded_rate, expected none, actual %0d",
                         $time, cmd_rate);
                n_fail++;
            end else begin
                want_cmd = expected_cmd_q.pop_front();
                if (cmd_rate !== want_cmd) begin
                    $display("%0t: commanded_rate mismatch, expected %0d, actual %0d",
                             $time, want_cmd, cmd_rate);
                    n_fail++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Shared drivers
    // ---------------------------------------------------------------
    // One register write; we is low again before the task returns, keeping one update per step.
    task automatic write_reg(input logic [hrc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hrc_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            hrc_pkg::REG_MAX_RATE:
                lim_max_rate  = data[hrc_pkg::MAX_RATE_W-1:0];
            hrc_pkg::REG_MAX_ACCEL:
                lim_max_accel = data[hrc_pkg::MAX_ACCEL_W-1:0];
            hrc_pkg::REG_MAX_RATE_STEP:
                lim_rate_step = data[hrc_pkg::RATE_STEP_W-1:0];
            default: ;  // outside the register file: dropped
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [hrc_pkg::CFG_DATA_W-1:0] rate_cap,
                              input logic [hrc_pkg::CFG_DATA_W-1:0] accel,
                              input logic [hrc_pkg::CFG_DATA_W-1:0] step);
        write_reg(hrc_pkg::REG_MAX_RATE, rate_cap);
        write_reg(hrc_pkg::REG_MAX_ACCEL, accel);
        write_reg(hrc_pkg::REG_MAX_RATE_STEP, step);
    endtask

    // Sends one request; valid stays up afterwards so back-to-back requests
    // never see a low/high pair in one step.
    task automatic send_heading(input logic [ANGLE_W-1:0]       tgt,
                                input logic [ANGLE_W-1:0]       meas,
                                input logic signed [RATE_W-1:0] rate);
        if (src_idle_pct != 0 && $urandom_range(99, 0) < src_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(18, 1)) @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        target_hdg <= tgt;
        meas_hdg   <= meas;
        meas_rate  <= rate;
        do @(posedge i_clk); while (!in_ready);
        expected_cmd_q.insert(expected_cmd_q.size(), predict_cmd_rate(tgt, meas, rate));
    endtask

    // Drop valid, wait for every predicted result, then let the pipe settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_cmd_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    // Random request: heading error biased toward zero, small, half-turn
    // neighborhood or anywhere; measured rate spread over all magnitudes.
    task automatic send_random_heading();
        logic [ANGLE_W-1:0]       meas;
        logic [ANGLE_W-1:0]       err;
        logic [31:0]              r;
        logic signed [RATE_W-1:0] rate;
        meas = $urandom;
        r    = $urandom;
        case ($urandom_range(5, 0))
            0: err = '0;
            1: err = {{(ANGLE_W-6){r[5]}}, r[5:0]};
            2: err = HALF_TURN + {{(ANGLE_W-6){r[5]}}, r[5:0]};
            default: err = r[ANGLE_W-1:0];
        endcase
        r = $urandom;
        case ($urandom_range(4, 0))
            0: rate = r[0] ? RATE_MAX_V : RATE_MIN_V;
            1: rate = r[RATE_W-1:0];
            default: begin
                rate = r[RATE_W-1:0];
                rate = rate >>> $urandom_range(RATE_W - 1, 0);
            end
        endcase
        send_heading(meas + err, meas, rate);
    endtask

    // One register value: zero, all ones (bit 23 exercises masking), random,
    // or random scaled down into the range where caps actually bite.
    function automatic logic [hrc_pkg::CFG_DATA_W-1:0] random_limit();
        logic [hrc_pkg::CFG_DATA_W-1:0] v;
        v = $urandom;
        case ($urandom_range(5, 0))
            0: v = '0;
            1: v = CFG_ALL_ONES;
            2: ;
            default: v = v >> $urandom_range(hrc_pkg::CFG_DATA_W - 1, 0);
        endcase
        return v;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // All limits zero after reset: the command must follow the measured rate.
    task automatic test_reset_state();
        send_heading(16'h4000, 16'h0000, RATE_MAX_V);
        send_heading(16'hC000, 16'h0000, RATE_MIN_V);
        send_heading(HALF_TURN, 16'h0000, '0);
        send_heading(16'h1234, 16'h8765, 24'sh0ABCDE);
        drain_results();
    endtask

    // Full-scale limits, then heading corners, then a zero and unit slew step.
    task automatic test_profile_corners();
        set_limits(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES);
        send_heading(16'h5A5A, 16'h5A5A, '0);          // zero error
        send_heading(HALF_TURN, 16'h0000, '0);         // half turn counts negative
        send_heading(16'h0000, HALF_TURN, '0);
        send_heading(16'h7FFF, 16'h0000, '0);          // largest positive error
        send_heading(16'h0000, 16'h7FFF, '0);          // mirror of the largest positive error
        send_heading(16'h0001, 16'h0000, '0);
        send_heading(ANGLE_MAX_V, 16'h0000, '0);       // wraps to -1
        send_heading(16'h4000, 16'h0000, RATE_MAX_V);
        send_heading(16'hC000, 16'h0000, RATE_MIN_V);
        send_heading(16'h1234, ANGLE_MAX_V, RATE_MIN_V);
        drain_results();
        write_reg(hrc_pkg::REG_MAX_RATE_STEP, '0);     // slew of zero pins to measured
        send_heading(16'h7FFF, 16'h0000, 24'sh123456);
        send_heading(HALF_TURN, 16'h0000, RATE_MIN_V);
        drain_results();
        write_reg(hrc_pkg::REG_MAX_RATE_STEP, 24'd1);
        send_heading(16'h7FFF, 16'h0000, '0);
        drain_results();
    endtask

    // A write past the register file must leave every limit as it was.
    task automatic test_register_decode();
        set_limits(24'd100, 24'd1000, 24'h7FFFFF);
        write_reg(REG_UNUSED, CFG_ALL_ONES);
        send_heading(16'h2000, 16'h0000, '0);
        send_heading(16'h0000, 16'h2000, 24'sd50);
        drain_results();
        write_reg(REG_UNUSED, '0);
        send_heading(16'h0010, 16'h0000, '0);
        drain_results();
    endtask

    // Random requests across many limit settings, with gaps and back-pressure;
    // some phases run without any idling.
    task automatic test_limit_sweep();
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: set_limits(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES);
                1: set_limits('0, CFG_ALL_ONES, CFG_ALL_ONES);
                2: set_limits(CFG_ALL_ONES, '0, 24'd1);
                3: set_limits(24'd4000, 24'd20000, 24'd300);
                default: set_limits(random_limit(), random_limit(), random_limit());
            endcase
            src_idle_pct   = (ph % 3 == 2) ? 0 : 20;
            sink_stall_pct = (ph % 3 == 2) ? 0 : 10;
            repeat (140) send_random_heading();
            drain_results();
        end
    endtask

    // Closing stretch: steady stream on both sides, pipeline kept full.
    task automatic test_unthrottled();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        for (int ph = 0; ph < 3; ph++) begin
            set_limits(random_limit(), random_limit(), random_limit());
            repeat (150) send_random_heading();
            drain_results();
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_profile_corners();
        test_register_decode();
        test_limit_sweep();
        test_unthrottled();
        if (n_fail == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

endmodule

### sim.f
design/hrc_pkg.sv
design/hrc_err.sv
design/hrc_sqrt.sv
design/hrc_slew.sv
design/heading_rate_controller.sv
tb/heading_rate_controller_tb.sv
